// File: src/olpe_pkg.sv
`default_nettype none

package olpe_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_AMEND  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT
  } state_t;

  // Broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    op_t         op;
    logic        commit;
    logic [4:0]  pos;
    logic [31:0] value;
    logic [31:0] query;
    logic        tok_start;
    logic        tok_clr;
  } olpe_cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/olpe_in_if.sv
`default_nettype none

interface olpe_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [4:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

`default_nettype wire

// File: src/olpe_out_if.sv
`default_nettype none

interface olpe_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] found_position;
  logic [4:0] entry_count;

  modport source (output valid, output status, output found_position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input found_position, input entry_count,
                  output ready);
endinterface

`default_nettype wire

// File: src/olpe_cell.sv
`default_nettype none

module olpe_cell import olpe_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire olpe_cell_ctrl_t ctrl,
  input  wire logic [31:0]     prev_data,
  input  wire logic [31:0]     next_data,
  input  wire logic            tok_in,
  output logic      [31:0]     data,
  output logic                 tok,
  output logic                 hit
);

  // 1-based list position held by this cell.
  localparam int SLOT = IDX + 1;

  logic [31:0] data_r, data_nxt;
  logic        tok_r, tok_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.commit) begin
      case (ctrl.op)
        OP_INSERT: begin
          if (SLOT > int'(ctrl.pos)) begin
            data_nxt = prev_data;
          end else if (SLOT == int'(ctrl.pos)) begin
            data_nxt = ctrl.value;
          end
        end
        OP_DELETE: begin
          if (SLOT >= int'(ctrl.pos)) begin
            data_nxt = next_data;
          end
        end
        OP_AMEND: begin
          if (SLOT == int'(ctrl.pos)) begin
            data_nxt = ctrl.value;
          end
        end
        default: begin
          data_nxt = data_r;
        end
      endcase
    end
    tok_nxt = ctrl.tok_clr ? 1'b0 : tok_in;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign data = data_r;
  assign tok  = tok_r;
  assign hit  = tok_r & (data_r == ctrl.query);

endmodule

`default_nettype wire

// File: src/ordered_list_position_engine.sv
`default_nettype none

// Channel   Port     Direction  Payload
// request   in_ch    sink       opcode[1:0], position[4:0], value[31:0] signed
// result    out_ch   source     status[1:0], found_position[4:0], entry_count[4:0]
//
// For insert, delete and amend the cell row updates at the accept edge and the result
// then moves through S_WAIT to the output register once that register is free.
// A search sends a scan token that walks the cell row one cell per cycle up to the last
// entry; a hit ends the walk early.
// Synchronous active-low reset empties the list; stored words are not cleared.
// A new request is taken while an earlier result still waits in the output register.

module ordered_list_position_engine import olpe_pkg::*; #(
  parameter int DEPTH = 16
) (
  input wire logic    clk,
  input wire logic    rst_n,
  olpe_in_if.sink     in_ch,
  olpe_out_if.source  out_ch
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [IW-1:0]   step_r, step_nxt;
  logic [31:0]     query_r, query_nxt;
  status_t         res_status_r, res_status_nxt;
  logic [4:0]      res_found_r, res_found_nxt;
  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;
  logic [4:0]      out_found_r, out_found_nxt;
  logic [4:0]      out_count_r, out_count_nxt;

  olpe_cell_ctrl_t ctrl;
  logic [31:0]     cell_data [DEPTH];
  logic            cell_tok  [DEPTH];
  logic [DEPTH-1:0] hit_vec;
  logic            hit_any;
  logic            accept;
  logic            full;
  logic            ins_ok;
  logic            pos_ok;
  logic [31:0]     pos32;
  logic [31:0]     cnt32;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [31:0] prev_d;
      logic [31:0] next_d;
      logic        tok_i;
      if (g == 0) begin : g_first
        assign prev_d = 32'd0;
        assign tok_i  = ctrl.tok_start;
      end else begin : g_mid
        assign prev_d = cell_data[g-1];
        assign tok_i  = cell_tok[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign next_d = 32'd0;
      end else begin : g_inner
        assign next_d = cell_data[g+1];
      end
      olpe_cell #(.IDX(g)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .prev_data (prev_d),
        .next_data (next_d),
        .tok_in    (tok_i),
        .data      (cell_data[g]),
        .tok       (cell_tok[g]),
        .hit       (hit_vec[g])
      );
    end
  endgenerate

  assign hit_any = |hit_vec;
  // No request is taken while reset is held.
  assign in_ch.ready = (state_r == S_IDLE) && rst_n;
  assign accept = in_ch.valid & in_ch.ready;
  assign pos32 = 32'(in_ch.position);
  assign cnt32 = 32'(count_r);
  assign full = (cnt32 == 32'(DEPTH));
  assign ins_ok = (pos32 >= 32'd1) && (pos32 <= cnt32 + 32'd1);
  assign pos_ok = (pos32 >= 32'd1) && (pos32 <= cnt32);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    query_nxt      = query_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;

    ctrl.op        = op_t'(in_ch.opcode);
    ctrl.commit    = 1'b0;
    ctrl.pos       = in_ch.position;
    ctrl.value     = in_ch.value;
    ctrl.query     = query_r;
    ctrl.tok_start = 1'b0;
    ctrl.tok_clr   = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_found_nxt = 5'd0;
          state_nxt     = S_WAIT;
          case (op_t'(in_ch.opcode))
            OP_INSERT: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else if (!ins_ok) begin
                res_status_nxt = ST_BADPOS;
              end else begin
                ctrl.commit    = 1'b1;
                count_nxt      = count_r + CW'(1);
                res_status_nxt = ST_OK;
              end
            end
            OP_DELETE: begin
              if (!pos_ok) begin
                res_status_nxt = ST_BADPOS;
              end else begin
                ctrl.commit    = 1'b1;
                count_nxt      = count_r - CW'(1);
                res_status_nxt = ST_OK;
              end
            end
            OP_AMEND: begin
              if (!pos_ok) begin
                res_status_nxt = ST_BADPOS;
              end else begin
                ctrl.commit    = 1'b1;
                res_status_nxt = ST_OK;
              end
            end
            OP_SEARCH: begin
              query_nxt = in_ch.value;
              if (count_r == '0) begin
                res_status_nxt = ST_NOTFOUND;
              end else begin
                ctrl.tok_start = 1'b1;
                step_nxt       = '0;
                state_nxt      = S_SCAN;
              end
            end
            default: begin
              res_status_nxt = ST_BADPOS;
            end
          endcase
        end
      end
      S_SCAN: begin
        // The token sits in the cell at list index step_r during this cycle.
        if (hit_any) begin
          res_status_nxt = ST_OK;
          res_found_nxt  = 5'(32'(step_r) + 32'd1);
          ctrl.tok_clr   = 1'b1;
          state_nxt      = S_WAIT;
        end else if (32'(step_r) + 32'd1 == cnt32) begin
          res_status_nxt = ST_NOTFOUND;
          res_found_nxt  = 5'd0;
          ctrl.tok_clr   = 1'b1;
          state_nxt      = S_WAIT;
        end else begin
          step_nxt = step_r + IW'(1);
        end
      end
      S_WAIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_count_nxt  = 5'(cnt32);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    query_r      <= query_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.found_position = out_found_r;
  assign out_ch.entry_count    = out_count_r;

endmodule

`default_nettype wire
